// File: rtl/rlt_pkg.sv
// ----------------------------------------------------------------------------
// rlt_pkg: report latency tracker shared definitions
// Event kinds, internal op codes, command word and result word layout.
// ----------------------------------------------------------------------------
`default_nettype none

package rlt_pkg;

  localparam int unsigned SLOT_COUNT_DEF = 128;
  localparam int unsigned CYC_PER_US_DEF = 480;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned NUM_OUT    = 12;
  localparam int unsigned IN_DATA_W  = 136;
  localparam int unsigned OUT_DATA_W = NUM_OUT * WORD_W;

  // event kinds on the input channel
  localparam logic [KIND_W-1:0] KIND_REPORT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ARM    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SUBMIT = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RF     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ERROR  = 3'd4;

  // result word slots
  localparam int unsigned W_TOTAL   = 0;
  localparam int unsigned W_USBDONE = 1;
  localparam int unsigned W_CONV    = 2;
  localparam int unsigned W_PROC    = 3;
  localparam int unsigned W_SUBMIT  = 4;
  localparam int unsigned W_USBLAT  = 5;
  localparam int unsigned W_USBAVG  = 6;
  localparam int unsigned W_RFLAT   = 7;
  localparam int unsigned W_RFAVG   = 8;
  localparam int unsigned W_RFOK    = 9;
  localparam int unsigned W_RFFAIL  = 10;
  localparam int unsigned W_ERR     = 11;

  typedef enum logic [2:0] {
    OP_REPORT = 3'd0,
    OP_ARM    = 3'd1,
    OP_SUBMIT = 3'd2,
    OP_RF     = 3'd3,
    OP_ERROR  = 3'd4,
    OP_NOP    = 3'd5
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [WORD_W-1:0] seq;
    logic [WORD_W-1:0] trig;
    logic [WORD_W-1:0] comp;
    logic [WORD_W-1:0] now;
    logic              ok;
  } cmd_t;

endpackage

`default_nettype wire

// File: rtl/rlt_front.sv
// ----------------------------------------------------------------------------
// rlt_front: event intake
// Accepts events, decodes the kind and queues commands for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rlt_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [rlt_pkg::IN_DATA_W-1:0]  in_tdata,  // seq, trigger, complete, now, ok
  input  wire logic [rlt_pkg::KIND_W-1:0]     in_tuser,  // kind
  output logic                                q_valid,
  input  wire logic                           q_ready,
  output rlt_pkg::cmd_t                       q_cmd
);

  localparam int unsigned DEPTH = 2;

  rlt_pkg::cmd_t     fifo_r [DEPTH];
  logic              wr_ptr_r;
  logic              rd_ptr_r;
  logic [1:0]        cnt_r;
  rlt_pkg::cmd_t     cmd_in;
  logic              push;
  logic              pop;

  always_comb begin
    cmd_in.seq  = in_tdata[31:0];
    cmd_in.trig = in_tdata[63:32];
    cmd_in.comp = in_tdata[95:64];
    cmd_in.now  = in_tdata[127:96];
    cmd_in.ok   = in_tdata[128];
    case (in_tuser)
      rlt_pkg::KIND_REPORT: cmd_in.op = rlt_pkg::OP_REPORT;
      rlt_pkg::KIND_ARM:    cmd_in.op = rlt_pkg::OP_ARM;
      rlt_pkg::KIND_SUBMIT: cmd_in.op = rlt_pkg::OP_SUBMIT;
      rlt_pkg::KIND_RF:     cmd_in.op = rlt_pkg::OP_RF;
      rlt_pkg::KIND_ERROR:  cmd_in.op = rlt_pkg::OP_ERROR;
      default:              cmd_in.op = rlt_pkg::OP_NOP;
    endcase
  end

  assign in_tready = (cnt_r != 2'(DEPTH));
  assign q_valid   = (cnt_r != 2'd0);
  assign q_cmd     = fifo_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/rlt_cdiv.sv
// ----------------------------------------------------------------------------
// rlt_cdiv: divide by a constant
// Reciprocal multiply, back-multiply and one correction step.
// ----------------------------------------------------------------------------
`default_nettype none

module rlt_cdiv #(
  parameter int unsigned DIVISOR = rlt_pkg::CYC_PER_US_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [rlt_pkg::WORD_W-1:0]  dividend,
  output logic                             done,
  output logic [rlt_pkg::WORD_W-1:0]       quot,
  output logic [rlt_pkg::WORD_W-1:0]       rem
);

  localparam int unsigned FL  = $clog2(DIVISOR + 1) - 1;
  localparam int unsigned SH  = 31 + FL;
  localparam logic [63:0] MUL = (64'd1 << SH) / 64'(DIVISOR);
  localparam logic [31:0] DV  = 32'(DIVISOR);

  logic [3:0]  ph_r;
  logic        done_r;
  logic [31:0] x_r;
  logic [63:0] prod_r;
  logic [31:0] q_r;
  logic [31:0] qd_r;
  logic [31:0] quot_r;
  logic [31:0] rem_r;
  logic [31:0] r;

  assign r    = x_r - qd_r;
  assign done = done_r;
  assign quot = quot_r;
  assign rem  = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= 4'd0;
      done_r <= 1'b0;
    end else begin
      ph_r   <= {ph_r[2:0], start};
      done_r <= ph_r[3];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= dividend;
    end
    if (ph_r[0]) begin
      prod_r <= 64'(x_r) * {32'd0, MUL[31:0]};
    end
    if (ph_r[1]) begin
      q_r <= 32'(prod_r >> SH);
    end
    if (ph_r[2]) begin
      qd_r <= 32'(64'(q_r) * 64'(DIVISOR));
    end
    if (ph_r[3]) begin
      if (r >= DV) begin
        quot_r <= q_r + 32'd1;
        rem_r  <= r - DV;
      end else begin
        quot_r <= q_r;
        rem_r  <= r;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/rlt_back.sv
// ----------------------------------------------------------------------------
// rlt_back: command execution
// Slot table, latency arithmetic through shared dividers, counters, output.
// ----------------------------------------------------------------------------
`default_nettype none

module rlt_back #(
  parameter int unsigned SLOT_COUNT = rlt_pkg::SLOT_COUNT_DEF,
  parameter int unsigned CYC_PER_US = rlt_pkg::CYC_PER_US_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           q_valid,
  output logic                                q_ready,
  input  wire rlt_pkg::cmd_t                  q_cmd,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [rlt_pkg::OUT_DATA_W-1:0]      out_tdata
);

  localparam int unsigned IDXW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_IDX  = 8'b00000010,
    S_RD   = 8'b00000100,
    S_CHK  = 8'b00001000,
    S_DIV  = 8'b00010000,
    S_SUM  = 8'b00100000,
    S_AVG  = 8'b01000000,
    S_OUT  = 8'b10000000
  } state_t;

  typedef struct packed {
    logic [31:0] tag;
    logic [31:0] trig;
    logic [31:0] comp;
    logic [31:0] rdy;
  } slot_t;

  state_t                   state_r;
  state_t                   state_nxt;
  rlt_pkg::cmd_t            cmd_r;
  logic [31:0]              key_r;
  logic [IDXW-1:0]          idx_r;
  logic [SLOT_COUNT-1:0]    vld_r;
  slot_t                    mem [SLOT_COUNT];
  slot_t                    mem_rd_r;
  logic                     mem_we;
  logic [IDXW-1:0]          mem_wa;
  logic [31:0]              sd_trig_r;
  logic [31:0]              sd_comp_r;
  logic [31:0]              sd_rdy_r;
  logic [1:0]               step_r;
  logic                     dbusy_r;
  logic                     armed_r;
  logic [31:0]              pend_tag_r;
  logic [rlt_pkg::NUM_OUT-1:0][31:0] cnt_r;
  logic                     out_valid_r;
  logic [rlt_pkg::OUT_DATA_W-1:0] out_data_r;

  logic                     pop;
  logic                     mod_start;
  logic [31:0]              mod_arg;
  logic                     mod_done;
  logic [31:0]              mod_quot;
  logic [31:0]              mod_rem;
  logic                     tdiv_start;
  logic [31:0]              tdiv_arg;
  logic                     tdiv_done;
  logic [31:0]              tdiv_quot;
  logic [31:0]              tdiv_rem;
  logic [31:0]              t_from;
  logic [31:0]              t_to;
  logic [3:0]               t_dst;
  logic                     hit;
  logic                     out_load;
  logic [33:0]              sum3;
  logic [31:0]              avg_old;
  logic [31:0]              avg_smp;
  logic [34:0]              blend;
  logic [31:0]              avg_new;

  assign q_ready    = (state_r == S_IDLE);
  assign pop        = q_valid && q_ready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_load   = (state_r == S_OUT) && (!out_valid_r || out_tready);

  // slot index = key mod SLOT_COUNT
  assign mod_arg   = (q_cmd.op == rlt_pkg::OP_SUBMIT) ? pend_tag_r : q_cmd.seq;
  assign mod_start = pop && ((q_cmd.op == rlt_pkg::OP_REPORT) ||
                             (q_cmd.op == rlt_pkg::OP_RF) ||
                             ((q_cmd.op == rlt_pkg::OP_SUBMIT) && armed_r));

  rlt_cdiv #(.DIVISOR(SLOT_COUNT)) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (mod_arg),
    .done     (mod_done),
    .quot     (mod_quot),
    .rem      (mod_rem)
  );

  always_comb begin
    case (step_r)
      2'd0: begin
        t_from = sd_trig_r;
        t_to   = sd_comp_r;
        t_dst  = 4'(rlt_pkg::W_CONV);
      end
      2'd1: begin
        t_from = sd_comp_r;
        t_to   = sd_rdy_r;
        t_dst  = 4'(rlt_pkg::W_PROC);
      end
      2'd2: begin
        t_from = sd_rdy_r;
        t_to   = cmd_r.now;
        t_dst  = 4'(rlt_pkg::W_SUBMIT);
      end
      default: begin
        t_from = sd_trig_r;
        t_to   = cmd_r.now;
        t_dst  = 4'(rlt_pkg::W_RFLAT);
      end
    endcase
  end

  assign tdiv_arg   = t_to - t_from;
  assign tdiv_start = (state_r == S_DIV) && !dbusy_r;

  rlt_cdiv #(.DIVISOR(CYC_PER_US)) u_tdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (tdiv_start),
    .dividend (tdiv_arg),
    .done     (tdiv_done),
    .quot     (tdiv_quot),
    .rem      (tdiv_rem)
  );

  assign hit = vld_r[idx_r] && (mem_rd_r.tag == key_r);

  assign sum3 = 34'(cnt_r[rlt_pkg::W_CONV]) + 34'(cnt_r[rlt_pkg::W_PROC]) +
                34'(cnt_r[rlt_pkg::W_SUBMIT]);

  assign avg_old = (cmd_r.op == rlt_pkg::OP_RF) ? cnt_r[rlt_pkg::W_RFAVG]
                                                : cnt_r[rlt_pkg::W_USBAVG];
  assign avg_smp = (cmd_r.op == rlt_pkg::OP_RF) ? cnt_r[rlt_pkg::W_RFLAT]
                                                : cnt_r[rlt_pkg::W_USBLAT];
  assign blend   = ({3'd0, avg_old} << 3) - {3'd0, avg_old} + {3'd0, avg_smp};
  assign avg_new = (avg_old == 32'd0) ? avg_smp : blend[34:3];

  assign mem_we = (state_r == S_IDX) && mod_done && (cmd_r.op == rlt_pkg::OP_REPORT);
  assign mem_wa = mod_rem[IDXW-1:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (pop) begin
          state_nxt = mod_start ? S_IDX : S_OUT;
        end
      end
      S_IDX: begin
        if (mod_done) begin
          state_nxt = (cmd_r.op == rlt_pkg::OP_REPORT) ? S_DIV : S_RD;
        end
      end
      S_RD:  state_nxt = S_CHK;
      S_CHK: state_nxt = hit ? S_DIV : S_OUT;
      S_DIV: begin
        if (tdiv_done) begin
          case (step_r)
            2'd0:    state_nxt = S_DIV;
            2'd1:    state_nxt = (cmd_r.op == rlt_pkg::OP_REPORT) ? S_OUT : S_DIV;
            2'd2:    state_nxt = S_SUM;
            default: state_nxt = S_AVG;
          endcase
        end
      end
      S_SUM: state_nxt = S_AVG;
      S_AVG: state_nxt = S_OUT;
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // slot table storage
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= '{tag: cmd_r.seq, trig: cmd_r.trig, comp: cmd_r.comp, rdy: cmd_r.now};
    end
    mem_rd_r <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_r <= q_cmd;
      key_r <= mod_arg;
    end
    if ((state_r == S_IDX) && mod_done) begin
      idx_r <= mod_rem[IDXW-1:0];
    end
    if (mem_we) begin
      sd_trig_r <= cmd_r.trig;
      sd_comp_r <= cmd_r.comp;
      sd_rdy_r  <= cmd_r.now;
    end else if ((state_r == S_CHK) && hit) begin
      sd_trig_r <= mem_rd_r.trig;
      sd_comp_r <= mem_rd_r.comp;
      sd_rdy_r  <= mem_rd_r.rdy;
    end
    if (out_load) begin
      out_data_r <= cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vld_r       <= '0;
      step_r      <= 2'd0;
      dbusy_r     <= 1'b0;
      armed_r     <= 1'b0;
      pend_tag_r  <= 32'd0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (pop) begin
        case (q_cmd.op)
          rlt_pkg::OP_REPORT: begin
            cnt_r[rlt_pkg::W_TOTAL] <= cnt_r[rlt_pkg::W_TOTAL] + 32'd1;
          end
          rlt_pkg::OP_ARM: begin
            pend_tag_r <= q_cmd.seq;
            armed_r    <= 1'b1;
          end
          rlt_pkg::OP_SUBMIT: begin
            cnt_r[rlt_pkg::W_USBDONE] <= cnt_r[rlt_pkg::W_USBDONE] + 32'd1;
            armed_r <= 1'b0;
          end
          rlt_pkg::OP_RF: begin
            if (q_cmd.ok) begin
              cnt_r[rlt_pkg::W_RFOK] <= cnt_r[rlt_pkg::W_RFOK] + 32'd1;
            end else begin
              cnt_r[rlt_pkg::W_RFFAIL] <= cnt_r[rlt_pkg::W_RFFAIL] + 32'd1;
            end
          end
          rlt_pkg::OP_ERROR: begin
            cnt_r[rlt_pkg::W_ERR] <= cnt_r[rlt_pkg::W_ERR] + 32'd1;
          end
          default: begin
          end
        endcase
      end

      if (mem_we) begin
        vld_r[mem_wa] <= 1'b1;
        step_r        <= 2'd0;
      end
      if ((state_r == S_CHK) && hit) begin
        step_r <= (cmd_r.op == rlt_pkg::OP_RF) ? 2'd3 : 2'd0;
      end

      if (tdiv_start) begin
        dbusy_r <= 1'b1;
      end
      if ((state_r == S_DIV) && tdiv_done) begin
        dbusy_r      <= 1'b0;
        cnt_r[t_dst] <= tdiv_quot;
        if (step_r != 2'd3) begin
          step_r <= step_r + 2'd1;
        end
      end

      if (state_r == S_SUM) begin
        cnt_r[rlt_pkg::W_USBLAT] <= (sum3[33:32] != 2'd0) ? 32'hFFFF_FFFF : sum3[31:0];
      end
      if (state_r == S_AVG) begin
        if (cmd_r.op == rlt_pkg::OP_RF) begin
          cnt_r[rlt_pkg::W_RFAVG] <= avg_new;
        end else begin
          cnt_r[rlt_pkg::W_USBAVG] <= avg_new;
        end
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/report_latency_tracker.sv
// Arm, error, unused kinds and an unarmed submit go straight to output; a slot
// miss ends at the table check; a report converts two intervals, an rf hit one
// plus its average, a usb submit hit three plus their sum and average. Events
// run one at a time; no new word is taken until the last result is loaded,
// which output stalls delay; a two-word queue decouples intake. Synchronous
// active-low reset clears slot valid bits, the pending arm and all counters.
// ----------------------------------------------------------------------------
// report_latency_tracker: report latency telemetry tracker
// Tracks report timestamps per sequence and derives usb and rf latencies.
// ----------------------------------------------------------------------------
`default_nettype none

module report_latency_tracker #(
  parameter int unsigned SLOT_COUNT = rlt_pkg::SLOT_COUNT_DEF,
  parameter int unsigned CYC_PER_US = rlt_pkg::CYC_PER_US_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [rlt_pkg::IN_DATA_W-1:0]  in_tdata,   // seq, trigger_cycles,
                                                           // complete_cycles, now_cycles, ok
  input  wire logic [rlt_pkg::KIND_W-1:0]     in_tuser,   // kind
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [rlt_pkg::OUT_DATA_W-1:0]      out_tdata   // total_reports, usb_reports_done,
                                                           // conversion_us, processing_us,
                                                           // submit_us, usb_latency_us,
                                                           // usb_latency_avg_us, rf_latency_us,
                                                           // rf_latency_avg_us, rf_ok_count,
                                                           // rf_fail_count, error_count
);

  logic          q_valid;
  logic          q_ready;
  rlt_pkg::cmd_t q_cmd;

  rlt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_cmd     (q_cmd)
  );

  rlt_back #(
    .SLOT_COUNT (SLOT_COUNT),
    .CYC_PER_US (CYC_PER_US)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_cmd      (q_cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: report latency tracker testbench
// Drives telemetry event words into the tracker and checks every result word
// against a latency predictor kept in a scoreboard. A directed burst covers
// slot hits and misses, arming, rearming, wrapped timestamps and unused kinds.
// Random report/arm/submit/rf sequences follow, mixed with noise, with random
// idling on both sides, a long output stall and a full drain pause.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import rlt_pkg::*;

  localparam int unsigned ITEM_TARGET = 1450;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned RECENT_MAX  = 24;
  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

  class latency_scoreboard;
    bit                  slot_live [SLOT_COUNT_DEF];
    bit [WORD_W-1:0]     slot_seq  [SLOT_COUNT_DEF];
    bit [WORD_W-1:0]     slot_trig [SLOT_COUNT_DEF];
    bit [WORD_W-1:0]     slot_comp [SLOT_COUNT_DEF];
    bit [WORD_W-1:0]     slot_rdy  [SLOT_COUNT_DEF];
    bit                  armed;
    bit [WORD_W-1:0]     armed_seq;
    bit [WORD_W-1:0]     stat [NUM_OUT];
    bit [OUT_DATA_W-1:0] expected_q [$];
    int unsigned         mismatches;
    int unsigned         checked;
    int unsigned         usb_hits;
    int unsigned         rf_hits;
    int unsigned         kind_seen [8];
    string field_name [NUM_OUT] = '{"total_reports", "usb_reports_done", "conversion_us",
                                    "processing_us", "submit_us", "usb_latency_us",
                                    "usb_latency_avg_us", "rf_latency_us",
                                    "rf_latency_avg_us", "rf_ok_count", "rf_fail_count",
                                    "error_count"};

    function bit [WORD_W-1:0] to_us(bit [WORD_W-1:0] from, bit [WORD_W-1:0] upto);
      bit [WORD_W-1:0] d;
      d = upto - from;
      return d / CYC_PER_US_DEF;
    endfunction

    // avg' = (7 * avg + sample) / 8, seeded when avg is zero
    function bit [WORD_W-1:0] smooth(bit [WORD_W-1:0] avg, bit [WORD_W-1:0] sample);
      bit [63:0] acc;
      if (avg == 0) return sample;
      acc = 64'(avg) * 7 + 64'(sample);
      return acc[34:3];
    endfunction

    function bit slot_hit(bit [WORD_W-1:0] s);
      int unsigned idx;
      idx = s % SLOT_COUNT_DEF;
      return slot_live[idx] && slot_seq[idx] == s;
    endfunction

    function void note_event(bit [KIND_W-1:0] kind, bit [WORD_W-1:0] seq,
                             bit [WORD_W-1:0] trig, bit [WORD_W-1:0] comp,
                             bit [WORD_W-1:0] now_cyc, bit ok);
      int unsigned         idx;
      bit [33:0]           total;
      bit [OUT_DATA_W-1:0] res;
      kind_seen[kind]++;
      case (kind)
        KIND_REPORT: begin
          idx = seq % SLOT_COUNT_DEF;
          slot_live[idx] = 1'b1;
          slot_seq[idx]  = seq;
          slot_trig[idx] = trig;
          slot_comp[idx] = comp;
          slot_rdy[idx]  = now_cyc;
          stat[W_TOTAL]++;
          stat[W_CONV] = to_us(trig, comp);
          stat[W_PROC] = to_us(comp, now_cyc);
        end
        KIND_ARM: begin
          armed_seq = seq;
          armed     = 1'b1;
        end
        KIND_SUBMIT: begin
          stat[W_USBDONE]++;
          if (armed) begin
            if (slot_hit(armed_seq)) begin
              idx = armed_seq % SLOT_COUNT_DEF;
              usb_hits++;
              stat[W_CONV]   = to_us(slot_trig[idx], slot_comp[idx]);
              stat[W_PROC]   = to_us(slot_comp[idx], slot_rdy[idx]);
              stat[W_SUBMIT] = to_us(slot_rdy[idx], now_cyc);
              total = 34'(stat[W_CONV]) + 34'(stat[W_PROC]) + 34'(stat[W_SUBMIT]);
              stat[W_USBLAT] = (total > 34'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
              stat[W_USBAVG] = smooth(stat[W_USBAVG], stat[W_USBLAT]);
            end
            armed = 1'b0;
          end
        end
        KIND_RF: begin
          if (ok) stat[W_RFOK]++;
          else stat[W_RFFAIL]++;
          if (slot_hit(seq)) begin
            rf_hits++;
            stat[W_RFLAT] = to_us(slot_trig[seq % SLOT_COUNT_DEF], now_cyc);
            stat[W_RFAVG] = smooth(stat[W_RFAVG], stat[W_RFLAT]);
          end
        end
        KIND_ERROR: begin
          stat[W_ERR]++;
        end
        default: begin
        end
      endcase
      for (int j = 0; j < NUM_OUT; j++) res[j*WORD_W +: WORD_W] = stat[j];
      expected_q.push_back(res);
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] got);
      bit [OUT_DATA_W-1:0] want;
      bit [WORD_W-1:0]     w;
      logic [WORD_W-1:0]   g;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("%0t: result word with nothing expected", $time);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      for (int j = 0; j < NUM_OUT; j++) begin
        w = want[j*WORD_W +: WORD_W];
        g = got[j*WORD_W +: WORD_W];
        if (g !== w) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: result %0d %s expected 0x%08h got 0x%08h",
                     $time, checked, field_name[j], w, g);
        end
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata  = '0;   // seq, trigger_cycles, complete_cycles, now_cycles, ok
  logic [KIND_W-1:0]     in_tuser  = '0;   // kind
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;        // twelve 32-bit counters, total_reports lowest

  latency_scoreboard sb;
  bit                tx_idle_en;
  bit                rx_idle_en;
  bit                hold_req;
  int unsigned       word_count;
  logic [WORD_W-1:0] tnow;
  logic [WORD_W-1:0] next_seq;
  logic [WORD_W-1:0] recent [$];

  report_latency_tracker dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("timeout, %0d result words still expected", sb.expected_q.size());
    $display("TEST FAILED");
    $finish;
  end

  // receiver: random backpressure, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        for (int i = 0; i < HOLD_CYCLES; i++) begin
          out_tready <= 1'b0;
          @(negedge clk);
        end
        hold_req = 1'b0;
      end
      out_tready <= !(rx_idle_en && $urandom_range(99) < 22);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_word(input logic [KIND_W-1:0] kind, input logic [WORD_W-1:0] seq,
                           input logic [WORD_W-1:0] trig, input logic [WORD_W-1:0] comp,
                           input logic [WORD_W-1:0] now_cyc, input logic ok);
    while (tx_idle_en && $urandom_range(99) < 22) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {7'd0, ok, now_cyc, comp, trig, seq};
    do @(posedge clk); while (!in_tready);
    sb.note_event(kind, seq, trig, comp, now_cyc, ok);
    if (kind <= KIND_ERROR) word_count++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
  endtask

  function automatic logic [WORD_W-1:0] gap_cycles();
    case ($urandom_range(9))
      0:       return $urandom;
      1, 2, 3: return $urandom_range(959);
      default: return $urandom_range(250000);
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] pick_recent();
    if (recent.size() == 0) return $urandom;
    return recent[$urandom_range(recent.size() - 1)];
  endfunction

  function automatic logic [WORD_W-1:0] fresh_seq();
    if ($urandom_range(99) < 3) next_seq = $urandom;
    next_seq++;
    return next_seq;
  endfunction

  task automatic post_report(input logic [WORD_W-1:0] s);
    logic [WORD_W-1:0] trig;
    logic [WORD_W-1:0] comp;
    trig = tnow + gap_cycles();
    comp = trig + gap_cycles();
    tnow = comp + gap_cycles();
    send_word(KIND_REPORT, s, trig, comp, tnow, 1'($urandom));
    recent.push_back(s);
    if (recent.size() > RECENT_MAX) void'(recent.pop_front());
  endtask

  task automatic post_simple(input logic [KIND_W-1:0] kind, input logic [WORD_W-1:0] s,
                             input logic ok);
    tnow = tnow + gap_cycles();
    send_word(kind, s, $urandom, $urandom, tnow, ok);
  endtask

  task automatic directed_checks();
    send_word(KIND_SPARE_LO, '1, '1, '1, '1, 1'b1);
    send_word(KIND_SPARE_HI, '1, '1, '1, '1, 1'b1);
    send_word(KIND_SUBMIT, '0, '0, '0, '0, 1'b0);              // submit, nothing armed
    send_word(KIND_ARM, 32'h0000_0005, '0, '0, '0, 1'b0);
    send_word(KIND_SUBMIT, '0, '0, '0, 32'h0000_1000, 1'b0);   // armed, table empty
    send_word(KIND_SUBMIT, '0, '0, '0, 32'h0000_2000, 1'b0);   // arm was cleared
    // timestamps wrapping through zero
    send_word(KIND_REPORT, '1, 32'hFFFF_FF00, 32'h0000_2000, 32'h0001_0000, 1'b0);
    send_word(KIND_REPORT, '0, '0, '1, '0, 1'b1);              // longest conversion
    send_word(KIND_ARM, '1, '0, '0, '0, 1'b0);
    send_word(KIND_ARM, '0, '0, '0, '0, 1'b0);                 // rearm replaces tag
    send_word(KIND_SUBMIT, '0, '0, '0, 32'h0100_0000, 1'b0);   // hit, seeds average
    send_word(KIND_ARM, '1, '0, '0, '0, 1'b0);
    send_word(KIND_SUBMIT, '0, '0, '0, 32'hFFFF_FFFF, 1'b1);   // hit, blends average
    send_word(KIND_ARM, 32'h0000_0080, '0, '0, '0, 1'b0);      // same slot, other tag
    send_word(KIND_SUBMIT, '0, '0, '0, 32'h0200_0000, 1'b0);
    send_word(KIND_RF, '0, '0, '0, 32'h0300_0000, 1'b1);       // hit, seeds rf average
    send_word(KIND_RF, '1, '0, '0, 32'h0000_0100, 1'b0);       // hit across wrap
    send_word(KIND_RF, 32'h0000_007F, '0, '0, '0, 1'b1);       // tag miss
    send_word(KIND_RF, 32'h0001_2345, '1, '1, '1, 1'b0);       // empty slot
    send_word(KIND_ERROR, '1, '1, '1, '1, 1'b1);
    send_word(KIND_ERROR, '0, '0, '0, '0, 1'b0);
    send_word(KIND_REPORT, 32'h0000_0080, 32'h10, 32'h2000, 32'h9000, 1'b0);  // evicts seq 0
    send_word(KIND_RF, '0, '0, '0, 32'h0000_A000, 1'b1);       // now a miss
    send_word(KIND_SPARE_HI, '0, '0, '0, '0, 1'b0);
    recent.push_back('1);
    recent.push_back(32'h0000_0080);
  endtask

  task automatic random_traffic();
    logic [WORD_W-1:0] s;
    bit                hold_done;
    bit                drain_done;
    int unsigned       r;
    hold_done  = 1'b0;
    drain_done = 1'b0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    while (word_count < ITEM_TARGET) begin
      if (word_count >= 400 && word_count < 650) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end else begin
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
      end
      if (!hold_done && word_count >= 800) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      if (!drain_done && word_count >= 1050) begin
        wait_drained();
        drain_done = 1'b1;
      end
      r = $urandom_range(99);
      if (r < 45) begin
        // report, optional noise, arm (sometimes rearmed), submit, optional rf
        s = fresh_seq();
        post_report(s);
        if ($urandom_range(3) == 0) post_simple(KIND_ERROR, $urandom, 1'($urandom));
        if ($urandom_range(4) == 0) post_simple(KIND_ARM, pick_recent(), 1'($urandom));
        post_simple(KIND_ARM, s, 1'($urandom));
        post_simple(KIND_SUBMIT, $urandom, 1'($urandom));
        if ($urandom_range(1) == 0) post_simple(KIND_RF, s, 1'($urandom));
      end else if (r < 65) begin
        post_simple(KIND_RF, pick_recent(), 1'($urandom));
      end else if (r < 75) begin
        post_simple(KIND_ARM, ($urandom_range(3) == 0) ? $urandom : pick_recent(),
                    1'($urandom));
        post_simple(KIND_SUBMIT, $urandom, 1'($urandom));
      end else if (r < 82) begin
        // same slot, different tag: evicts the older entry
        s = pick_recent();
        post_report(s + SLOT_COUNT_DEF * $urandom_range(1, 40));
        post_simple(KIND_RF, s, 1'($urandom));
      end else if (r < 90) begin
        post_simple(($urandom_range(1) == 0) ? KIND_SUBMIT : KIND_ERROR, $urandom,
                    1'($urandom));
      end else begin
        send_word(3'($urandom_range(7)), $urandom, $urandom, $urandom, $urandom,
                  1'($urandom));
      end
    end
  endtask

  initial begin
    sb       = new();
    tnow     = $urandom;
    next_seq = $urandom;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    directed_checks();
    random_traffic();
    in_tvalid <= 1'b0;
    wait_drained();
    repeat (40) @(posedge clk);
    if (sb.expected_q.size() != 0) sb.mismatches += sb.expected_q.size();
    $display("Events: %0d reports, %0d arms, %0d submits (%0d table hits), %0d rf (%0d hits)",
             sb.kind_seen[KIND_REPORT], sb.kind_seen[KIND_ARM], sb.kind_seen[KIND_SUBMIT],
             sb.usb_hits, sb.kind_seen[KIND_RF], sb.rf_hits);
    $display("%0d errors, %0d unused kinds; %0d result words checked, %0d mismatches",
             sb.kind_seen[KIND_ERROR], sb.kind_seen[5] + sb.kind_seen[6] + sb.kind_seen[7],
             sb.checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
